/* src/izh_pkg.sv */
// ----------------------------------------------------------------------------
// izh_pkg
// shared widths, s16.15 constants, register indexes and fixed-point helpers
// for the izhikevich rk2 step block
// ----------------------------------------------------------------------------
package izh_pkg;

  localparam int unsigned XW     = 32;  // s16.15 word
  localparam int unsigned TSW    = 31;  // timestep register width
  localparam int unsigned ADDR_W = 5;   // eight word registers
  localparam int unsigned IDX_W  = 3;

  typedef logic signed [XW-1:0] fx_t;
  typedef logic [IDX_W-1:0]     reg_idx_t;

  // constants in units of 2^-15
  localparam fx_t K_140   = 32'sd4587520;
  localparam fx_t K_5     = 32'sd163840;
  localparam fx_t K_0P04  = 32'sd1311;
  localparam fx_t K_30    = 32'sd983040;
  localparam fx_t K_1P85  = 32'sd60621;
  localparam fx_t K_1P001 = 32'sd32801;

  // register map (word index)
  localparam reg_idx_t REG_A      = 3'd0;
  localparam reg_idx_t REG_B      = 3'd1;
  localparam reg_idx_t REG_C      = 3'd2;
  localparam reg_idx_t REG_D      = 3'd3;
  localparam reg_idx_t REG_OFFSET = 3'd4;
  localparam reg_idx_t REG_TSTEP  = 3'd5;
  localparam reg_idx_t REG_INIT_V = 3'd6;
  localparam reg_idx_t REG_INIT_U = 3'd7;

  // reset values
  localparam fx_t             RST_A      = 32'sd655;
  localparam fx_t             RST_B      = 32'sd6554;
  localparam fx_t             RST_C      = -32'sd2129920;
  localparam fx_t             RST_D      = 32'sd65536;
  localparam fx_t             RST_OFFSET = 32'sd0;
  localparam logic [TSW-1:0]  RST_TSTEP  = 31'd32768;
  localparam fx_t             RST_INIT_V = -32'sd2129920;
  localparam fx_t             RST_INIT_U = -32'sd425984;

  // full product, floor shift by 15, wrap to 32 bits
  function automatic fx_t fx_mul(fx_t x, fx_t y);
    logic signed [2*XW-1:0] p;
    p = x * y;
    return fx_t'(p[XW+14:15]);
  endfunction

  function automatic fx_t fx_half(fx_t x);
    return x >>> 1;
  endfunction

endpackage

/* src/izh_if.sv */
// ----------------------------------------------------------------------------
// izh_in_if / izh_out_if
// valid/ready stream channels for timestep beats and result beats
// ----------------------------------------------------------------------------
interface izh_in_if import izh_pkg::*; ();
  logic valid;
  logic ready;
  fx_t  excitatory_current;
  fx_t  inhibitory_current;
  fx_t  bias_current;

  modport source (output valid, excitatory_current, inhibitory_current, bias_current,
                  input ready);
  modport sink   (input valid, excitatory_current, inhibitory_current, bias_current,
                  output ready);
endinterface

interface izh_out_if import izh_pkg::*; ();
  logic valid;
  logic ready;
  logic spiked;
  fx_t  membrane_voltage;

  modport source (output valid, spiked, membrane_voltage, input ready);
  modport sink   (input valid, spiked, membrane_voltage, output ready);
endinterface

/* src/izhikevich_neuron_rk2_step.sv */
// ----------------------------------------------------------------------------
// izhikevich_neuron_rk2_step
// one izhikevich neuron, one rk2 midpoint step per input beat, s16.15 math
// ----------------------------------------------------------------------------
// channel   dir  handshake        payload
// in_i      in   valid/ready      excitatory_current, inhibitory_current,
//                                 bias_current (s16.15 each)
// out_o     out  valid/ready      spiked, membrane_voltage (s16.15)
// apb       in   psel/penable     eight 32-bit registers at 4*index
//
// the result beat is registered when the final step retires; the first beat
// after reset also runs an init step, which loads v, u and h from the
// initial registers; a new beat is taken only once the sequencer is back in
// idle; the step sequence is set by the single shared 32x32 multiplier, used once
// per sequencer step
// reset is asynchronous, active low, and returns the neuron to idle
// the result sits in an output register, so the next beat is accepted while
// it waits; only the final step stalls if the previous result is still held
// ----------------------------------------------------------------------------
module izhikevich_neuron_rk2_step import izh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  izh_in_if.sink            in_i,
  izh_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [XW-1:0]     pwdata,
  output logic [XW-1:0]     prdata,
  output logic              pready
);

  // sequencer, one multiply per step
  typedef enum logic [14:0] {
    ST_IDLE  = 15'h0001,
    ST_INIT  = 15'h0002,  // first beat: load v, u, h
    ST_CUR0  = 15'h0004,
    ST_CUR1  = 15'h0008,
    ST_CUR2  = 15'h0010,
    ST_PRE   = 15'h0020,
    ST_ALPHA = 15'h0040,
    ST_ETA0  = 15'h0080,
    ST_ETA1  = 15'h0100,
    ST_DV0   = 15'h0200,
    ST_DV1   = 15'h0400,
    ST_DV2   = 15'h0800,
    ST_DV3   = 15'h1000,
    ST_VUPD  = 15'h2000,
    ST_FIN   = 15'h4000
  } state_e;

  state_e state_q, state_d;
  logic   started_q, started_d;
  logic   out_valid_q, out_valid_d;

  // configuration registers
  fx_t            a_q, b_q, c_q, d_q, offset_q, init_v_q, init_u_q;
  logic [TSW-1:0] tstep_q;

  // neuron state and step temporaries
  fx_t  v_q, u_q, h_q;
  fx_t  exc_q, inh_q, bias_q;
  fx_t  pre_q, acc_q, t1_q, t2_q, t3_q, beta_q, eta_q;
  logic out_spiked_q;
  fx_t  out_v_q;

  fx_t  mul_a, mul_b, mul_p;
  fx_t  tstep_ext;
  fx_t  v_new;
  logic spike;
  logic in_acc, fin_go, cfg_wr;
  reg_idx_t cfg_idx;

  assign tstep_ext = fx_t'({1'b0, tstep_q});

  // ---------------------------------------------------------------------------
  // apb register port, no wait states
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q      <= RST_A;
      b_q      <= RST_B;
      c_q      <= RST_C;
      d_q      <= RST_D;
      offset_q <= RST_OFFSET;
      tstep_q  <= RST_TSTEP;
      init_v_q <= RST_INIT_V;
      init_u_q <= RST_INIT_U;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_A:      a_q      <= fx_t'(pwdata);
        REG_B:      b_q      <= fx_t'(pwdata);
        REG_C:      c_q      <= fx_t'(pwdata);
        REG_D:      d_q      <= fx_t'(pwdata);
        REG_OFFSET: offset_q <= fx_t'(pwdata);
        REG_TSTEP:  tstep_q  <= pwdata[TSW-1:0];
        REG_INIT_V: init_v_q <= fx_t'(pwdata);
        REG_INIT_U: init_u_q <= fx_t'(pwdata);
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_A:      prdata = a_q;
      REG_B:      prdata = b_q;
      REG_C:      prdata = c_q;
      REG_D:      prdata = d_q;
      REG_OFFSET: prdata = offset_q;
      REG_TSTEP:  prdata = {1'b0, tstep_q};
      REG_INIT_V: prdata = init_v_q;
      REG_INIT_U: prdata = init_u_q;
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshakes
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  // last step only retires once the output register is free
  assign fin_go     = (state_q == ST_FIN) & (~out_valid_q | out_o.ready);

  assign out_o.valid            = out_valid_q;
  assign out_o.spiked           = out_spiked_q;
  assign out_o.membrane_voltage = out_v_q;

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    started_d   = started_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    unique case (state_q)
      ST_IDLE:  if (in_acc) begin
                  state_d = started_q ? ST_CUR0 : ST_INIT;
                end
      ST_INIT:  begin
                  state_d   = ST_CUR0;
                  started_d = 1'b1;
                end
      ST_CUR0:  state_d = ST_CUR1;
      ST_CUR1:  state_d = ST_CUR2;
      ST_CUR2:  state_d = ST_PRE;
      ST_PRE:   state_d = ST_ALPHA;
      ST_ALPHA: state_d = ST_ETA0;
      ST_ETA0:  state_d = ST_ETA1;
      ST_ETA1:  state_d = ST_DV0;
      ST_DV0:   state_d = ST_DV1;
      ST_DV1:   state_d = ST_DV2;
      ST_DV2:   state_d = ST_DV3;
      ST_DV3:   state_d = ST_VUPD;
      ST_VUPD:  state_d = ST_FIN;
      ST_FIN:   if (fin_go) begin
                  state_d     = ST_IDLE;
                  out_valid_d = 1'b1;
                end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiplier operand select
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (state_q)
      ST_INIT:  begin mul_a = tstep_ext; mul_b = K_1P001; end  // initial h
      ST_CUR0:  begin mul_a = K_0P04;    mul_b = v_q;     end
      ST_CUR1:  begin mul_a = b_q;       mul_b = v_q;     end
      ST_CUR2:  begin mul_a = t1_q;      mul_b = v_q;     end  // (5 + 0.04v)v
      ST_PRE:   begin mul_a = h_q;       mul_b = t2_q;    end  // h(bv - u)
      ST_ALPHA: begin mul_a = t2_q;      mul_b = a_q;     end
      ST_ETA0:  begin mul_a = h_q;       mul_b = t1_q;    end  // h*alpha
      ST_ETA1:  begin mul_a = a_q;       mul_b = h_q;     end
      ST_DV0:   begin mul_a = K_0P04;    mul_b = eta_q;   end
      ST_DV1:   begin mul_a = b_q;       mul_b = eta_q;   end
      ST_DV2:   begin mul_a = t1_q;      mul_b = eta_q;   end
      ST_DV3:   begin mul_a = t2_q;      mul_b = t3_q;    end  // ah*du
      ST_VUPD:  begin mul_a = h_q;       mul_b = t1_q;    end  // h*dv
      ST_FIN:   begin mul_a = tstep_ext; mul_b = K_1P85;  end  // post-spike h
      default:  begin mul_a = '0;        mul_b = '0;      end
    endcase
  end

  assign mul_p = fx_mul(mul_a, mul_b);

  // threshold test on the updated voltage
  assign v_new = v_q + t1_q;
  assign spike = (v_new >= K_30);

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE:  if (in_acc) begin
                  exc_q  <= in_i.excitatory_current;
                  inh_q  <= in_i.inhibitory_current;
                  bias_q <= in_i.bias_current;
                end
      ST_INIT:  begin
                  v_q <= init_v_q;
                  u_q <= init_u_q;
                  h_q <= mul_p;
                end
      ST_CUR0:  begin
                  pre_q <= exc_q - inh_q;
                  t1_q  <= mul_p;
                end
      ST_CUR1:  begin
                  pre_q <= pre_q + bias_q;
                  t1_q  <= K_5 + t1_q;
                  t2_q  <= mul_p;
                end
      ST_CUR2:  begin
                  pre_q <= pre_q + offset_q;
                  t1_q  <= mul_p;
                  t2_q  <= t2_q - u_q;
                end
      ST_PRE:   begin
                  pre_q <= pre_q - u_q + K_140;
                  t2_q  <= mul_p;
                end
      ST_ALPHA: begin
                  t1_q   <= pre_q + t1_q;  // alpha
                  beta_q <= mul_p;
                end
      ST_ETA0:  begin
                  t1_q   <= mul_p;
                  beta_q <= fx_half(beta_q);
                end
      ST_ETA1:  begin
                  eta_q <= v_q + fx_half(t1_q);
                  t2_q  <= mul_p;  // a*h
                end
      ST_DV0:   t1_q <= mul_p;
      ST_DV1:   begin
                  t1_q  <= K_5 + t1_q;
                  acc_q <= pre_q - beta_q;
                  t3_q  <= mul_p;
                end
      ST_DV2:   begin
                  t1_q <= mul_p;
                  t3_q <= t3_q - u_q - beta_q;  // du
                end
      ST_DV3:   begin
                  t1_q <= acc_q + t1_q;  // dv
                  t3_q <= mul_p;
                end
      ST_VUPD:  begin
                  t1_q <= mul_p;
                  u_q  <= u_q + t3_q;
                end
      ST_FIN:   if (fin_go) begin
                  v_q          <= spike ? c_q : v_new;
                  u_q          <= spike ? (u_q + d_q) : u_q;
                  h_q          <= spike ? mul_p : tstep_ext;
                  out_spiked_q <= spike;
                  out_v_q      <= spike ? c_q : v_new;
                end
      default:  ;
    endcase
  end

endmodule

/* src/izh_checker.sv */
// ----------------------------------------------------------------------------
// izh_checker
// port-level checks for izhikevich_neuron_rk2_step, attached by bind
// ----------------------------------------------------------------------------
module izh_checker import izh_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_spiked_i,
  input fx_t  out_voltage_i
);

  logic in_acc;
  assign in_acc = in_valid_i & in_ready_i;

  // held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_spiked_i)
                                    && $stable(out_voltage_i))
    else $error("result beat changed while stalled");

  // one beat in flight: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input accepted again while computing");

  // a new result does not rise too soon after an input accept
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_acc) && !$past(in_acc, 2) && !$past(in_acc, 3))
    else $error("result too soon after input beat");

  // a step without a spike ends below threshold
  a_no_spike: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_spiked_i |-> out_voltage_i < K_30)
    else $error("voltage at threshold without spike");

endmodule

bind izhikevich_neuron_rk2_step izh_checker u_izh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_spiked_i  (out_o.spiked),
  .out_voltage_i (out_o.membrane_voltage)
);
